// ===== src/avs_pkg.sv =====
// Shared types, constants and codes of the A/V sync frame scheduler.
`timescale 1ns / 1ps
package avs_pkg;

  localparam int VIDEO_DEPTH  = 512;
  localparam int AUDIO_DEPTH  = 512;
  localparam int SESSION_BITS = 16;
  localparam int TIME_BITS    = 48;
  localparam int HANDLE_BITS  = 32;

  localparam int VID_AW = $clog2(VIDEO_DEPTH);
  localparam int VID_CW = $clog2(VIDEO_DEPTH + 1);
  localparam int AUD_AW = $clog2(AUDIO_DEPTH);
  localparam int AUD_CW = $clog2(AUDIO_DEPTH + 1);

  localparam int REQ_W    = 3;
  localparam int KIND_W   = 3;
  localparam int MARK_W   = 10;
  localparam int US_W     = 20;
  localparam int DROP_W   = 21;
  localparam int ABS_W    = 20;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 21;
  localparam int DIFF_W   = TIME_BITS + 4;
  localparam int ABS_MAX  = (1 << ABS_W) - 1;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Request codes on the req_type input.
  localparam logic [REQ_W-1:0] REQ_VIDEO_ARRIVE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_AUDIO_ARRIVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_VIDEO_TICK   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_AUDIO_TICK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR        = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SESSION      = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_PAUSE_HIGH = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_RESUME_LOW = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_LATENCY    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_LEAD       = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_HOLD       = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_DROP       = 3'd5;

  localparam logic [MARK_W-1:0]        PAUSE_HIGH_RST = 10'd256;
  localparam logic [MARK_W-1:0]        RESUME_LOW_RST = 10'd128;
  localparam logic [US_W-1:0]          LATENCY_RST    = 20'd120000;
  localparam logic [US_W-1:0]          LEAD_RST       = 20'd100000;
  localparam logic [US_W-1:0]          HOLD_RST       = 20'd15000;
  localparam logic signed [DROP_W-1:0] DROP_RST       = -21'sd100000;

  typedef enum logic [2:0] {
    CMD_VIDEO_ARRIVE,
    CMD_AUDIO_ARRIVE,
    CMD_VIDEO_TICK,
    CMD_AUDIO_TICK,
    CMD_CLEAR,
    CMD_SESSION,
    CMD_IGNORE
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE     = 3'd0,
    KIND_RENDER_V = 3'd1,
    KIND_RENDER_A = 3'd2,
    KIND_LATE     = 3'd3,
    KIND_STALE_V  = 3'd4,
    KIND_STALE_A  = 3'd5,
    KIND_FULL     = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_VREAD,
    BS_VSUB1,
    BS_VSUB2,
    BS_VDEC,
    BS_AREAD
  } bstate_e;

  typedef struct packed {
    logic [MARK_W-1:0]        pause_high;
    logic [MARK_W-1:0]        resume_low;
    logic [US_W-1:0]          latency;
    logic [US_W-1:0]          lead;
    logic [US_W-1:0]          hold_thr;
    logic signed [DROP_W-1:0] drop_thr;
  } cfg_t;

  typedef struct packed {
    cmd_e                    cmd;
    logic [SESSION_BITS-1:0] session;
    logic [TIME_BITS-1:0]    pts;
    logic [HANDLE_BITS-1:0]  handle;
    logic [TIME_BITS:0]      clk_adj;
  } cmd_t;

  typedef struct packed {
    logic [SESSION_BITS-1:0] session;
    logic [TIME_BITS-1:0]    pts;
    logic [HANDLE_BITS-1:0]  handle;
  } frame_t;

  typedef struct packed {
    kind_e                  kind;
    logic [HANDLE_BITS-1:0] handle;
    logic [TIME_BITS-1:0]   pts;
    logic [ABS_W-1:0]       abs_diff;
    logic                   pause_valid;
    logic                   pause_on;
    logic [VID_CW-1:0]      video_count;
    logic [AUD_CW-1:0]      audio_count;
  } result_t;

endpackage

// ===== src/avs_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module avs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/avs_queue.sv =====
// Short command queue between the front and the back of the scheduler.
`timescale 1ns / 1ps
module avs_queue import avs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  cmd_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] count_q, count_d;
  logic           do_push, do_pop;

  assign full_o  = (count_q == QCW'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/avs_front.sv =====
// Front end: accepts commands, classifies the request and prepares the audio clock.
`timescale 1ns / 1ps
module avs_front import avs_pkg::*; (
  input  logic                           start_i,
  input  logic [REQ_W-1:0]               req_type_i,
  input  logic [SESSION_BITS-1:0]        session_id_i,
  input  logic signed [TIME_BITS-1:0]    pts_us_i,
  input  logic [HANDLE_BITS-1:0]         frame_handle_i,
  input  logic signed [TIME_BITS-1:0]    audio_clock_us_i,
  input  cfg_t                           cfg_i,
  input  logic                           q_full_i,
  output logic                           busy_o,
  output logic                           push_o,
  output cmd_t                           cmd_o
);

  logic signed [TIME_BITS:0] clk_adj;

  // Audio clock less the output latency; one bit wider so it cannot wrap.
  assign clk_adj = (TIME_BITS + 1)'(audio_clock_us_i)
                 - $signed((TIME_BITS + 1)'(cfg_i.latency));

  assign busy_o = q_full_i;
  assign push_o = start_i && !q_full_i;

  always_comb begin
    cmd_o.session = session_id_i;
    cmd_o.pts     = pts_us_i;
    cmd_o.handle  = frame_handle_i;
    cmd_o.clk_adj = clk_adj;
    unique case (req_type_i)
      REQ_VIDEO_ARRIVE: cmd_o.cmd = CMD_VIDEO_ARRIVE;
      REQ_AUDIO_ARRIVE: cmd_o.cmd = CMD_AUDIO_ARRIVE;
      REQ_VIDEO_TICK:   cmd_o.cmd = CMD_VIDEO_TICK;
      REQ_AUDIO_TICK:   cmd_o.cmd = CMD_AUDIO_TICK;
      REQ_CLEAR:        cmd_o.cmd = CMD_CLEAR;
      REQ_SESSION:      cmd_o.cmd = CMD_SESSION;
      default:          cmd_o.cmd = CMD_IGNORE;
    endcase
  end

endmodule

// ===== src/avs_back.sv =====
// Back end: frame queues, time base and the sync decision sequencer.
`timescale 1ns / 1ps
module avs_back import avs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    q_empty_i,
  input  cmd_t    q_data_i,
  output logic    q_pop_o,
  output logic    res_valid_o,
  output result_t res_o
);

  localparam int FRAME_W = $bits(frame_t);

  bstate_e                  state_q, state_d;
  logic [VID_AW-1:0]        video_head_q, video_head_d;
  logic [VID_CW-1:0]        video_fill_q, video_fill_d;
  logic [AUD_AW-1:0]        audio_head_q, audio_head_d;
  logic [AUD_CW-1:0]        audio_fill_q, audio_fill_d;
  logic [SESSION_BITS-1:0]  cur_sess_q, cur_sess_d;
  logic                     base_valid_q, base_valid_d;
  logic [TIME_BITS-1:0]     time_base_q, time_base_d;
  cmd_t                     cmd_q, cmd_d;
  frame_t                   frm_q, frm_d;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  result_t                  res_q, res_d;
  logic                     res_valid_q, res_valid_d;

  logic                 vram_we, vram_re, aram_we, aram_re;
  logic [VID_AW-1:0]    vram_waddr;
  logic [AUD_AW-1:0]    aram_waddr;
  frame_t               wframe, vframe, aframe;
  logic [FRAME_W-1:0]   vram_rdata, aram_rdata;
  logic [VID_CW:0]      vsum, vtail;
  logic [AUD_CW:0]      asum, atail;
  logic [VID_AW-1:0]    video_head_inc;
  logic [AUD_AW-1:0]    audio_head_inc;

  logic signed [DIFF_W-1:0] hold_ext, drop_ext, base_term;
  logic [DIFF_W-1:0]        abs_full;
  logic [ABS_W-1:0]         abs_sat;

  assign vframe = frame_t'(vram_rdata);
  assign aframe = frame_t'(aram_rdata);

  assign wframe.session = q_data_i.session;
  assign wframe.pts     = q_data_i.pts;
  assign wframe.handle  = q_data_i.handle;

  // Tail slot = head + fill, wrapped at the queue depth.
  assign vsum  = (VID_CW + 1)'(video_head_q) + (VID_CW + 1)'(video_fill_q);
  assign vtail = (vsum >= (VID_CW + 1)'(VIDEO_DEPTH)) ? vsum - (VID_CW + 1)'(VIDEO_DEPTH)
                                                     : vsum;
  assign asum  = (AUD_CW + 1)'(audio_head_q) + (AUD_CW + 1)'(audio_fill_q);
  assign atail = (asum >= (AUD_CW + 1)'(AUDIO_DEPTH)) ? asum - (AUD_CW + 1)'(AUDIO_DEPTH)
                                                     : asum;
  assign vram_waddr = vtail[VID_AW-1:0];
  assign aram_waddr = atail[AUD_AW-1:0];

  assign video_head_inc = (video_head_q == VID_AW'(VIDEO_DEPTH - 1)) ? '0
                                                                     : video_head_q + 1'b1;
  assign audio_head_inc = (audio_head_q == AUD_AW'(AUDIO_DEPTH - 1)) ? '0
                                                                     : audio_head_q + 1'b1;

  assign hold_ext  = $signed(DIFF_W'(cfg_i.hold_thr));
  assign drop_ext  = DIFF_W'(cfg_i.drop_thr);
  assign base_term = base_valid_q ? DIFF_W'($signed(time_base_q)) : '0;
  assign abs_full  = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
  assign abs_sat   = (abs_full > DIFF_W'(ABS_MAX)) ? ABS_W'(ABS_MAX) : abs_full[ABS_W-1:0];

  avs_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (VIDEO_DEPTH)
  ) u_video_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (wframe),
    .re_i    (vram_re),
    .raddr_i (video_head_q),
    .rdata_o (vram_rdata)
  );

  avs_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (AUDIO_DEPTH)
  ) u_audio_ram (
    .clk_i   (clk_i),
    .we_i    (aram_we),
    .waddr_i (aram_waddr),
    .wdata_i (wframe),
    .re_i    (aram_re),
    .raddr_i (audio_head_q),
    .rdata_o (aram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    video_head_d = video_head_q;
    video_fill_d = video_fill_q;
    audio_head_d = audio_head_q;
    audio_fill_d = audio_fill_q;
    cur_sess_d   = cur_sess_q;
    base_valid_d = base_valid_q;
    time_base_d  = time_base_q;
    cmd_d        = cmd_q;
    frm_d        = frm_q;
    diff_d       = diff_q;
    res_d        = '0;
    res_valid_d  = 1'b0;
    q_pop_o      = 1'b0;
    vram_we      = 1'b0;
    vram_re      = 1'b0;
    aram_we      = 1'b0;
    aram_re      = 1'b0;

    unique case (state_q)
      BS_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_data_i;
          unique case (q_data_i.cmd)
            CMD_VIDEO_ARRIVE: begin
              res_valid_d = 1'b1;
              if (video_fill_q == VID_CW'(VIDEO_DEPTH)) begin
                res_d.kind   = KIND_FULL;
                res_d.handle = q_data_i.handle;
                res_d.pts    = q_data_i.pts;
              end else begin
                vram_we      = 1'b1;
                video_fill_d = video_fill_q + 1'b1;
              end
              if (video_fill_d >= cfg_i.pause_high) begin
                res_d.pause_valid = 1'b1;
                res_d.pause_on    = 1'b1;
              end
            end
            CMD_AUDIO_ARRIVE: begin
              res_valid_d = 1'b1;
              if (!base_valid_q) begin
                time_base_d  = q_data_i.pts;
                base_valid_d = 1'b1;
              end
              if (audio_fill_q == AUD_CW'(AUDIO_DEPTH)) begin
                res_d.kind   = KIND_FULL;
                res_d.handle = q_data_i.handle;
                res_d.pts    = q_data_i.pts;
              end else begin
                aram_we      = 1'b1;
                audio_fill_d = audio_fill_q + 1'b1;
              end
            end
            CMD_VIDEO_TICK: begin
              if (video_fill_q == '0) begin
                res_valid_d = 1'b1;
              end else begin
                vram_re = 1'b1;
                state_d = BS_VREAD;
              end
            end
            CMD_AUDIO_TICK: begin
              if (audio_fill_q == '0) begin
                res_valid_d = 1'b1;
              end else begin
                aram_re = 1'b1;
                state_d = BS_AREAD;
              end
            end
            CMD_CLEAR: begin
              res_valid_d  = 1'b1;
              video_head_d = '0;
              video_fill_d = '0;
              audio_head_d = '0;
              audio_fill_d = '0;
              base_valid_d = 1'b0;
            end
            CMD_SESSION: begin
              res_valid_d  = 1'b1;
              cur_sess_d   = q_data_i.session;
              base_valid_d = 1'b0;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end

      BS_VREAD: begin
        frm_d = vframe;
        if (vframe.session != cur_sess_q) begin
          res_valid_d   = 1'b1;
          res_d.kind    = KIND_STALE_V;
          res_d.handle  = vframe.handle;
          res_d.pts     = vframe.pts;
          video_head_d  = video_head_inc;
          video_fill_d  = video_fill_q - 1'b1;
          state_d       = BS_IDLE;
        end else begin
          diff_d  = DIFF_W'($signed(vframe.pts)) - base_term;
          state_d = BS_VSUB1;
        end
      end

      BS_VSUB1: begin
        diff_d  = diff_q - DIFF_W'($signed(cmd_q.clk_adj));
        state_d = BS_VSUB2;
      end

      BS_VSUB2: begin
        diff_d  = diff_q - $signed(DIFF_W'(cfg_i.lead));
        state_d = BS_VDEC;
      end

      BS_VDEC: begin
        res_valid_d = 1'b1;
        state_d     = BS_IDLE;
        if (diff_q >= hold_ext) begin
          res_d.kind = KIND_NONE;
        end else begin
          res_d.handle = frm_q.handle;
          res_d.pts    = frm_q.pts;
          video_head_d = video_head_inc;
          video_fill_d = video_fill_q - 1'b1;
          if (diff_q < drop_ext) begin
            res_d.kind = KIND_LATE;
          end else begin
            res_d.kind     = KIND_RENDER_V;
            res_d.abs_diff = abs_sat;
            if (video_fill_d < cfg_i.resume_low) begin
              res_d.pause_valid = 1'b1;
              res_d.pause_on    = 1'b0;
            end
          end
        end
      end

      BS_AREAD: begin
        res_valid_d  = 1'b1;
        res_d.kind   = (aframe.session != cur_sess_q) ? KIND_STALE_A : KIND_RENDER_A;
        res_d.handle = aframe.handle;
        res_d.pts    = aframe.pts;
        audio_head_d = audio_head_inc;
        audio_fill_d = audio_fill_q - 1'b1;
        state_d      = BS_IDLE;
      end

      default: begin
        state_d = BS_IDLE;
      end
    endcase

    res_d.video_count = video_fill_d;
    res_d.audio_count = audio_fill_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BS_IDLE;
      video_head_q <= '0;
      video_fill_q <= '0;
      audio_head_q <= '0;
      audio_fill_q <= '0;
      cur_sess_q   <= '0;
      base_valid_q <= 1'b0;
      time_base_q  <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      video_head_q <= video_head_d;
      video_fill_q <= video_fill_d;
      audio_head_q <= audio_head_d;
      audio_fill_q <= audio_fill_d;
      cur_sess_q   <= cur_sess_d;
      base_valid_q <= base_valid_d;
      time_base_q  <= time_base_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    frm_q  <= frm_d;
    diff_q <= diff_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_video_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    video_fill_q <= VID_CW'(VIDEO_DEPTH))
    else $error("video fill count beyond the queue depth");

  a_audio_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    audio_fill_q <= AUD_CW'(AUDIO_DEPTH))
    else $error("audio fill count beyond the queue depth");

  a_full_needs_full_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.kind == KIND_FULL) |->
      (res_q.video_count == VID_CW'(VIDEO_DEPTH) ||
       res_q.audio_count == AUD_CW'(AUDIO_DEPTH)))
    else $error("full reported while neither queue is full");

  a_abs_only_on_render: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.kind != KIND_RENDER_V) |-> (res_q.abs_diff == '0))
    else $error("sync difference reported on a result that is not a video render");

  a_pause_on_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.pause_valid && res_q.pause_on) |->
      (res_q.kind == KIND_NONE || res_q.kind == KIND_FULL))
    else $error("pause signalled on a result other than a video arrival");

endmodule

// ===== src/av_sync_frame_scheduler_core.sv =====
// Top level of the audio-master A/V sync frame scheduler.
`timescale 1ns / 1ps
// The block keeps a video and an audio frame queue and decides, on each video
// tick, whether the head video frame is held, dropped as late, or rendered.
// A command is transferred at a rising edge where start_i is high and busy_o
// is low; busy_o rises only when the two-entry command queue between the
// front and back ends is full. Exactly one result follows each command, shown
// for one cycle with result_valid_o high; the receiver cannot stall it, so it
// must take every result as it appears.
// An arrival, clear, session change or empty-queue tick has its result
// registered as the back end pops it; an audio tick or stale video frame adds
// the read state, and a judged video tick the read, two subtraction states
// and the decision. The back end handles one command at a time, so throughput
// is set by that sequencer: one command per cycle for arrivals while no
// earlier tick holds it, the cost being the registered frame-store read and
// the subtraction chain. Configuration is written through cfg_we_i, cfg_idx_i
// and cfg_wdata_i while the block is idle; the user must ensure this, as the
// block does not enforce it. Reset clears the queue pointers, fill counts,
// session and time base at once; the frame stores need no clearing pass.
module av_sync_frame_scheduler_core import avs_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IW-1:0]           cfg_idx_i,
  input  logic [CFG_DW-1:0]           cfg_wdata_i,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [REQ_W-1:0]            req_type_i,
  input  logic [SESSION_BITS-1:0]     session_id_i,
  input  logic signed [TIME_BITS-1:0] pts_us_i,
  input  logic [HANDLE_BITS-1:0]      frame_handle_i,
  input  logic signed [TIME_BITS-1:0] audio_clock_us_i,
  output logic                        result_valid_o,
  output logic [KIND_W-1:0]           out_kind_o,
  output logic [HANDLE_BITS-1:0]      out_handle_o,
  output logic signed [TIME_BITS-1:0] out_pts_us_o,
  output logic [ABS_W-1:0]            sync_err_us_o,
  output logic                        pause_valid_o,
  output logic                        pause_on_o,
  output logic [VID_CW-1:0]           video_count_o,
  output logic [AUD_CW-1:0]           audio_count_o
);

  cfg_t    cfg_q, cfg_d;
  cmd_t    push_cmd, q_head;
  logic    push, q_full, q_empty, q_pop;
  logic    res_valid;
  result_t res;

  // Configuration registers; indexes beyond the list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAUSE_HIGH: cfg_d.pause_high = cfg_wdata_i[MARK_W-1:0];
        CFG_RESUME_LOW: cfg_d.resume_low = cfg_wdata_i[MARK_W-1:0];
        CFG_LATENCY:    cfg_d.latency    = cfg_wdata_i[US_W-1:0];
        CFG_LEAD:       cfg_d.lead       = cfg_wdata_i[US_W-1:0];
        CFG_HOLD:       cfg_d.hold_thr   = cfg_wdata_i[US_W-1:0];
        CFG_DROP:       cfg_d.drop_thr   = $signed(cfg_wdata_i[DROP_W-1:0]);
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pause_high <= PAUSE_HIGH_RST;
      cfg_q.resume_low <= RESUME_LOW_RST;
      cfg_q.latency    <= LATENCY_RST;
      cfg_q.lead       <= LEAD_RST;
      cfg_q.hold_thr   <= HOLD_RST;
      cfg_q.drop_thr   <= DROP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end classifies each command and folds the output latency into
  // the audio clock, so the back end sees one subtraction fewer.
  avs_front u_front (
    .start_i          (start_i),
    .req_type_i       (req_type_i),
    .session_id_i     (session_id_i),
    .pts_us_i         (pts_us_i),
    .frame_handle_i   (frame_handle_i),
    .audio_clock_us_i (audio_clock_us_i),
    .cfg_i            (cfg_q),
    .q_full_i         (q_full),
    .busy_o           (busy_o),
    .push_o           (push),
    .cmd_o            (push_cmd)
  );

  avs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .empty_o (q_empty)
  );

  // The back end owns both frame stores and runs the per-command sequence.
  avs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_data_i    (q_head),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign result_valid_o = res_valid;
  assign out_kind_o     = res.kind;
  assign out_handle_o   = res.handle;
  assign out_pts_us_o   = res.pts;
  assign sync_err_us_o  = res.abs_diff;
  assign pause_valid_o  = res.pause_valid;
  assign pause_on_o     = res.pause_on;
  assign video_count_o  = res.video_count;
  assign audio_count_o  = res.audio_count;

endmodule

// ===== dv/av_sync_frame_scheduler_core_test.sv =====
// Self-checking testbench for the audio-master A/V sync frame scheduler core.
`timescale 1ns / 1ps
module av_sync_frame_scheduler_core_test;
  import avs_pkg::*;

  // The two request codes that the block has no use for; it must answer them
  // with an empty result.
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  localparam logic [TIME_BITS-1:0] PTS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [TIME_BITS-1:0] PTS_MIN = 48'h8000_0000_0000;

  // Nominal frame period used to build well-formed streams.
  localparam int FRAME_US    = 33333;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 30;

  typedef struct {
    logic [REQ_W-1:0]        req;
    logic [SESSION_BITS-1:0] session;
    logic [TIME_BITS-1:0]    pts;
    logic [HANDLE_BITS-1:0]  handle;
    logic [TIME_BITS-1:0]    clock;
    int unsigned             gap;
    bit                      drain;
  } req_item_t;

  // Ports of the block. Every input starts from a known value.
  logic                        clk_i            = 1'b0;
  logic                        rst_ni           = 1'b0;
  logic                        cfg_we_i         = 1'b0;
  logic [CFG_IW-1:0]           cfg_idx_i        = '0;
  logic [CFG_DW-1:0]           cfg_wdata_i      = '0;
  logic                        start_i          = 1'b0;
  logic                        busy_o;
  logic [REQ_W-1:0]            req_type_i       = '0;
  logic [SESSION_BITS-1:0]     session_id_i     = '0;
  logic signed [TIME_BITS-1:0] pts_us_i         = '0;
  logic [HANDLE_BITS-1:0]      frame_handle_i   = '0;
  logic signed [TIME_BITS-1:0] audio_clock_us_i = '0;
  logic                        result_valid_o;
  logic [KIND_W-1:0]           out_kind_o;
  logic [HANDLE_BITS-1:0]      out_handle_o;
  logic signed [TIME_BITS-1:0] out_pts_us_o;
  logic [ABS_W-1:0]            sync_err_us_o;
  logic                        pause_valid_o;
  logic                        pause_on_o;
  logic [VID_CW-1:0]           video_count_o;
  logic [AUD_CW-1:0]           audio_count_o;

  av_sync_frame_scheduler_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .req_type_i       (req_type_i),
    .session_id_i     (session_id_i),
    .pts_us_i         (pts_us_i),
    .frame_handle_i   (frame_handle_i),
    .audio_clock_us_i (audio_clock_us_i),
    .result_valid_o   (result_valid_o),
    .out_kind_o       (out_kind_o),
    .out_handle_o     (out_handle_o),
    .out_pts_us_o     (out_pts_us_o),
    .sync_err_us_o    (sync_err_us_o),
    .pause_valid_o    (pause_valid_o),
    .pause_on_o       (pause_on_o),
    .video_count_o    (video_count_o),
    .audio_count_o    (audio_count_o)
  );

  always #6 clk_i = ~clk_i;

  // Requests waiting to be driven, and the outcomes owed by the block for
  // requests it has already taken, oldest first.
  req_item_t requests_pending[$];
  result_t   outcomes_due[$];

  // The scheduler state as this bench sees it. The frame queues are modelled
  // as plain queues: only entries that were written are ever looked at.
  frame_t                  video_fifo[$];
  frame_t                  audio_fifo[$];
  logic [SESSION_BITS-1:0] current_sess = '0;
  bit                      base_known   = 1'b0;
  logic [TIME_BITS-1:0]    time_base    = '0;
  cfg_t live_cfg = '{PAUSE_HIGH_RST, RESUME_LOW_RST, LATENCY_RST, LEAD_RST, HOLD_RST,
                     DROP_RST};

  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned queued_total   = 0;
  int unsigned cycle_count    = 0;

  // Stimulus shaping: no idling while quiet is set, and the next request
  // added is held back until every outstanding outcome has arrived.
  bit                      quiet         = 1'b0;
  bit                      hold_off_next = 1'b0;
  logic [SESSION_BITS-1:0] gen_sess      = '0;

  // Works out what the block must answer to one request and moves the model
  // state on. Every request yields exactly one outcome.
  function automatic result_t schedule_outcome(req_item_t it);
    result_t r;
    frame_t  f;
    longint  vt, diff, mag, clk_v, lat, lead, hold, drop;
    r = '0;
    r.kind = KIND_NONE;
    case (it.req)
      REQ_VIDEO_ARRIVE: begin
        if (video_fifo.size() >= VIDEO_DEPTH) begin
          r.kind   = KIND_FULL;
          r.handle = it.handle;
          r.pts    = it.pts;
        end else begin
          f.session = it.session;
          f.pts     = it.pts;
          f.handle  = it.handle;
          video_fifo.push_back(f);
        end
        // The pause request is raised even when the arrival was turned away.
        if (video_fifo.size() >= live_cfg.pause_high) begin
          r.pause_valid = 1'b1;
          r.pause_on    = 1'b1;
        end
      end
      REQ_AUDIO_ARRIVE: begin
        // The first audio arrival fixes the time base, full queue or not.
        if (!base_known) begin
          time_base  = it.pts;
          base_known = 1'b1;
        end
        if (audio_fifo.size() >= AUDIO_DEPTH) begin
          r.kind   = KIND_FULL;
          r.handle = it.handle;
          r.pts    = it.pts;
        end else begin
          f.session = it.session;
          f.pts     = it.pts;
          f.handle  = it.handle;
          audio_fifo.push_back(f);
        end
      end
      REQ_VIDEO_TICK: begin
        if (video_fifo.size() != 0) begin
          f        = video_fifo[0];
          r.handle = f.handle;
          r.pts    = f.pts;
          if (f.session != current_sess) begin
            r.kind = KIND_STALE_V;
            void'(video_fifo.pop_front());
          end else begin
            // At these widths the difference never leaves the 64-bit range,
            // so plain arithmetic matches the block's wide difference register.
            vt = $signed(f.pts);
            if (base_known) vt = vt - $signed(time_base);
            clk_v = $signed(it.clock);
            lat   = live_cfg.latency;
            lead  = live_cfg.lead;
            hold  = live_cfg.hold_thr;
            drop  = $signed(live_cfg.drop_thr);
            diff  = vt - (clk_v - lat) - lead;
            if (diff >= hold) begin
              // Too early: the frame stays at the head and nothing is named.
              r.handle = '0;
              r.pts    = '0;
            end else begin
              if (diff < drop) begin
                r.kind = KIND_LATE;
              end else begin
                r.kind     = KIND_RENDER_V;
                mag        = (diff < 0) ? -diff : diff;
                r.abs_diff = (mag > ABS_MAX) ? ABS_W'(ABS_MAX) : mag[ABS_W-1:0];
              end
              void'(video_fifo.pop_front());
              if (r.kind == KIND_RENDER_V && video_fifo.size() < live_cfg.resume_low) begin
                r.pause_valid = 1'b1;
                r.pause_on    = 1'b0;
              end
            end
          end
        end
      end
      REQ_AUDIO_TICK: begin
        if (audio_fifo.size() != 0) begin
          f        = audio_fifo.pop_front();
          r.handle = f.handle;
          r.pts    = f.pts;
          r.kind   = (f.session != current_sess) ? KIND_STALE_A : KIND_RENDER_A;
        end
      end
      REQ_CLEAR: begin
        video_fifo.delete();
        audio_fifo.delete();
        base_known = 1'b0;
      end
      REQ_SESSION: begin
        current_sess = it.session;
        base_known   = 1'b0;
      end
      default: begin
      end
    endcase
    r.video_count = VID_CW'(video_fifo.size());
    r.audio_count = AUD_CW'(audio_fifo.size());
    return r;
  endfunction

  // Driver. A request is transferred at an edge where start_i is high and
  // busy_o is low; the outcome is predicted at that same edge. The next
  // request then waits out its own gap and, if marked, the draining of every
  // outstanding outcome before start_i is raised for it.
  req_item_t on_port;
  req_item_t next_req;
  bit        staged = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) outcomes_due.push_back(schedule_outcome(on_port));
      if (!start_i || !busy_o) begin
        if (!staged && requests_pending.size() != 0) begin
          next_req = requests_pending.pop_front();
          staged   = 1'b1;
        end
        if (staged && next_req.gap != 0) begin
          next_req.gap = next_req.gap - 1;
          start_i <= 1'b0;
        end else if (staged && (!next_req.drain || outcomes_due.size() == 0)) begin
          on_port = next_req;
          staged  = 1'b0;
          start_i          <= 1'b1;
          req_type_i       <= next_req.req;
          session_id_i     <= next_req.session;
          pts_us_i         <= next_req.pts;
          frame_handle_i   <= next_req.handle;
          audio_clock_us_i <= next_req.clock;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string what, logic [TIME_BITS-1:0] got,
                             logic [TIME_BITS-1:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d, %s: got %0h, expected %0h",
                              results_seen, what, got, want));
  endtask

  // Monitor. Results cannot be held off, so each strobe is taken as it comes
  // and compared with the oldest outcome still owed.
  result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (outcomes_due.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                results_seen));
      end else begin
        want = outcomes_due.pop_front();
        check_field("out_kind", TIME_BITS'(out_kind_o), TIME_BITS'(want.kind));
        check_field("out_handle", TIME_BITS'(out_handle_o), TIME_BITS'(want.handle));
        check_field("out_pts_us", out_pts_us_o, want.pts);
        check_field("sync_err_us", TIME_BITS'(sync_err_us_o), TIME_BITS'(want.abs_diff));
        check_field("pause_valid", TIME_BITS'(pause_valid_o),
                    TIME_BITS'(want.pause_valid));
        check_field("pause_on", TIME_BITS'(pause_on_o), TIME_BITS'(want.pause_on));
        check_field("video_count", TIME_BITS'(video_count_o),
                    TIME_BITS'(want.video_count));
        check_field("audio_count", TIME_BITS'(audio_count_o),
                    TIME_BITS'(want.audio_count));
      end
    end
  end

  // Watchdog: a lost result or a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [TIME_BITS-1:0] any48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_BITS-1:0];
  endfunction

  function automatic logic [SESSION_BITS-1:0] any16();
    return SESSION_BITS'($urandom);
  endfunction

  // Idle cycles before a request: mostly none or a few, now and then a long
  // stretch, and none at all while quiet is set.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  task automatic add_item(logic [REQ_W-1:0] req, logic [SESSION_BITS-1:0] sess,
                          logic [TIME_BITS-1:0] pts, logic [HANDLE_BITS-1:0] hnd,
                          logic [TIME_BITS-1:0] clk_v);
    req_item_t it;
    it.req     = req;
    it.session = sess;
    it.pts     = pts;
    it.handle  = hnd;
    it.clock   = clk_v;
    it.gap     = pick_gap();
    it.drain   = hold_off_next;
    hold_off_next = 1'b0;
    requests_pending.push_back(it);
    queued_total++;
  endtask

  // Waits until nothing is queued, in flight or owed, then lets the longest
  // pipeline latency pass again before the block is treated as idle.
  task automatic settle();
    do @(negedge clk_i);
    while (requests_pending.size() != 0 || staged || start_i || outcomes_due.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
  endtask

  // Writes every register; only ever called with the block idle, so the
  // model copy can take the new values straight away.
  task automatic write_config(cfg_t c);
    cfg_write(CFG_PAUSE_HIGH, CFG_DW'(c.pause_high));
    cfg_write(CFG_RESUME_LOW, CFG_DW'(c.resume_low));
    cfg_write(CFG_LATENCY, CFG_DW'(c.latency));
    cfg_write(CFG_LEAD, CFG_DW'(c.lead));
    cfg_write(CFG_HOLD, CFG_DW'(c.hold_thr));
    cfg_write(CFG_DROP, c.drop_thr);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    live_cfg = c;
  endtask

  function automatic cfg_t make_cfg(int ph, int rl, int lat, int lead, int hold, int drop);
    cfg_t c;
    c.pause_high = ph[MARK_W-1:0];
    c.resume_low = rl[MARK_W-1:0];
    c.latency    = lat[US_W-1:0];
    c.lead       = lead[US_W-1:0];
    c.hold_thr   = hold[US_W-1:0];
    c.drop_thr   = drop[DROP_W-1:0];
    return c;
  endfunction

  function automatic cfg_t random_cfg();
    return make_cfg($urandom_range(40, 1), $urandom_range(40), $urandom_range(1000000),
                    $urandom_range(1000000), $urandom_range(200000),
                    -int'($urandom_range(200000)));
  endfunction

  // One playback episode: a session change, the audio frame that sets the
  // time base, then a mix of arrivals and ticks. Frames are spaced a frame
  // period apart and each video tick moves the audio clock on by one period
  // with some jitter, so the head frame is held, dropped or rendered in turn.
  task automatic run_episode(bit drain_first);
    logic [SESSION_BITS-1:0] sess;
    logic [TIME_BITS-1:0]    base;
    longint                  t;
    int                      vid_n, aud_n, tick_k, len, pick, jit;
    quiet         = ($urandom_range(2) == 0);
    hold_off_next = drain_first;
    if ($urandom_range(3) == 0) begin
      // Same session again: flush first so old frames cannot wedge the head.
      sess = gen_sess;
      add_item(REQ_CLEAR, any16(), any48(), $urandom, any48());
    end else begin
      sess = any16();
    end
    gen_sess = sess;
    add_item(REQ_SESSION, sess, any48(), $urandom, any48());
    base = any48();
    base[TIME_BITS-1:TIME_BITS-2] = {2{base[TIME_BITS-3]}};
    add_item(REQ_AUDIO_ARRIVE, sess, base, $urandom, any48());
    vid_n  = 0;
    aud_n  = 1;
    tick_k = 0;
    len    = $urandom_range(80, 20);
    repeat (len) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        jit = int'($urandom_range(4000)) - 2000;
        t   = longint'($signed(base)) + longint'(vid_n) * FRAME_US + jit;
        add_item(REQ_VIDEO_ARRIVE, ($urandom_range(9) == 0) ? 16'($urandom) : sess,
                 t[TIME_BITS-1:0], $urandom, any48());
        vid_n++;
      end else if (pick < 65) begin
        if ($urandom_range(4) == 0) jit = int'($urandom_range(600000)) - 300000;
        else jit = int'($urandom_range(80000)) - 40000;
        t = longint'(tick_k) * FRAME_US + longint'(live_cfg.latency)
            - longint'(live_cfg.lead) + jit;
        add_item(REQ_VIDEO_TICK, any16(), any48(), $urandom, t[TIME_BITS-1:0]);
        tick_k++;
      end else if (pick < 80) begin
        t = longint'($signed(base)) + longint'(aud_n) * FRAME_US;
        add_item(REQ_AUDIO_ARRIVE, ($urandom_range(9) == 0) ? 16'($urandom) : sess,
                 t[TIME_BITS-1:0], $urandom, any48());
        aud_n++;
      end else if (pick < 95) begin
        add_item(REQ_AUDIO_TICK, any16(), any48(), $urandom, any48());
      end else if (pick < 98) begin
        add_item(3'($urandom), any16(), any48(), $urandom, any48());
      end else begin
        add_item(REQ_CLEAR, any16(), any48(), $urandom, any48());
        break;
      end
    end
  endtask

  task automatic run_phase(cfg_t c, int unsigned budget);
    int unsigned first, ep;
    settle();
    write_config(c);
    first = queued_total;
    ep    = 0;
    while (queued_total - first < budget) begin
      run_episode(ep % 2 == 0);
      ep++;
    end
  endtask

  // Pushes both queues past full with a trickle of ticks, then empties them
  // partly and clears. Half the video frames belong to the live session.
  task automatic fill_both();
    for (int i = 0; i < 525; i++) begin
      quiet = (i >= 262);
      add_item(REQ_VIDEO_ARRIVE, $urandom_range(1) ? gen_sess : 16'($urandom), any48(),
               $urandom, any48());
      add_item(REQ_AUDIO_ARRIVE, any16(), any48(), $urandom, any48());
      if ($urandom_range(99) == 0)
        add_item(REQ_VIDEO_TICK, any16(), any48(), $urandom, any48());
      if ($urandom_range(99) == 0)
        add_item(REQ_AUDIO_TICK, any16(), any48(), $urandom, any48());
    end
    repeat (10) begin
      add_item(REQ_VIDEO_TICK, any16(), any48(), $urandom, any48());
      add_item(REQ_AUDIO_TICK, any16(), any48(), $urandom, any48());
    end
    add_item(REQ_CLEAR, any16(), any48(), $urandom, any48());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening at the reset settings: the comments give the outcome
    // expected of a request, and for three video ticks the difference too.
    add_item(REQ_VIDEO_TICK, 16'hFFFF, PTS_MAX, '1, PTS_MAX);     // empty queue
    add_item(REQ_AUDIO_TICK, '0, '0, '0, '0);                     // empty queue
    add_item(REQ_SPARE_HI, '1, '1, '1, '1);
    add_item(REQ_SPARE_LO, '0, '0, '0, '0);
    add_item(REQ_AUDIO_ARRIVE, '0, PTS_MAX, '1, PTS_MIN);         // sets the time base
    add_item(REQ_AUDIO_ARRIVE, 16'hFFFF, PTS_MIN, '0, PTS_MAX);
    add_item(REQ_VIDEO_ARRIVE, '0, PTS_MAX, 32'h1, '0);
    add_item(REQ_VIDEO_ARRIVE, '0, PTS_MAX - 48'd50000, 32'h2, '0);
    add_item(REQ_VIDEO_TICK, '0, '0, '0, 48'd100000);              // -80000: render
    add_item(REQ_VIDEO_ARRIVE, 16'hFFFF, '0, 32'h3, '0);
    add_item(REQ_VIDEO_TICK, '0, '0, '0, -48'sd200000);            // 170000: hold
    add_item(REQ_VIDEO_TICK, '0, '0, '0, 48'd200000);              // -230000: late
    add_item(REQ_VIDEO_TICK, '0, '0, '0, '0);                      // wrong session
    add_item(REQ_AUDIO_TICK, '0, '0, '0, '0);                      // render audio
    add_item(REQ_AUDIO_TICK, '0, '0, '0, '0);                      // wrong session
    add_item(REQ_SESSION, 16'hFFFF, '0, '0, '0);
    add_item(REQ_VIDEO_ARRIVE, 16'hFFFF, 48'd5000, 32'h4, '0);
    add_item(REQ_VIDEO_TICK, '0, '0, '0, PTS_MIN);                 // no base yet: hold
    add_item(REQ_VIDEO_TICK, '0, '0, '0, PTS_MAX);                 // far behind: late
    add_item(REQ_AUDIO_ARRIVE, 16'hFFFF, 48'd12345, 32'h5, '0);
    add_item(REQ_CLEAR, '1, '1, '1, '1);
    add_item(REQ_VIDEO_ARRIVE, 16'hFFFF, '0, 32'h6, '0);
    add_item(REQ_VIDEO_TICK, '0, '0, '0, 48'd5000);                // exactly hold
    add_item(REQ_VIDEO_TICK, '0, '0, '0, 48'd5001);                // just under hold
    add_item(REQ_VIDEO_ARRIVE, 16'hFFFF, '0, 32'h7, '0);
    add_item(REQ_VIDEO_TICK, '0, '0, '0, 48'd120000);              // exactly drop
    add_item(REQ_VIDEO_ARRIVE, 16'hFFFF, '0, 32'h8, '0);
    add_item(REQ_VIDEO_TICK, '0, '0, '0, 48'd120001);              // just past drop
    gen_sess = 16'hFFFF;

    // Low watermarks so pause and resume come often, then the wide extremes.
    run_phase(make_cfg(4, 2, 120000, 100000, 15000, -100000), 40);
    run_phase(make_cfg(1, 512, 1000000, 1000000, 1000000, -1000000), 30);

    // Zero thresholds meet, so no video frame can render; both queues overflow.
    settle();
    write_config(make_cfg(512, 0, 0, 0, 0, 0));
    fill_both();

    run_phase(random_cfg(), 30);

    settle();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== av_sync_frame_scheduler_core.f =====
src/avs_pkg.sv
src/avs_ram.sv
src/avs_queue.sv
src/avs_front.sv
src/avs_back.sv
src/av_sync_frame_scheduler_core.sv
dv/av_sync_frame_scheduler_core_test.sv
